// ----- rtl/core/rfr_pkg.sv -----
// Report frame receiver package: phase and event codes, register indexes,
// reset values and the structs shared by the frame parser and the top level.
// No dependencies.
package rfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  localparam logic [ByteW-1:0]  FirstStartRst  = 8'hBE;
  localparam logic [ByteW-1:0]  SecondStartRst = 8'hEF;
  localparam logic [CountW-1:0] TimeoutRst     = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_START  = 2'd0,
    CFG_SECOND_START = 2'd1,
    CFG_TIMEOUT      = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    PH_START0  = 6'b000001,
    PH_START1  = 6'b000010,
    PH_ID      = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CHECK   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [ByteW-1:0]  first_start_byte;
    logic [ByteW-1:0]  second_start_byte;
    logic [CountW-1:0] timeout_limit_ms;
  } cfg_t;

  typedef struct packed {
    ev_kind_t          event_kind;
    logic [ByteW-1:0]  report_id;
    logic [ByteW-1:0]  byte_index;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  payload_length;
    logic [ByteW-1:0]  checksum_residual;
    logic [CountW-1:0] invalid_total;
    logic [CountW-1:0] timeout_total;
  } result_t;

endpackage

// ----- rtl/core/rfr_if.sv -----
// Valid/ready channel interfaces of the report frame receiver: input items
// (byte or tick) and result events. No dependencies.
interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface rfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  report_id;
  logic [7:0]  byte_index;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_length;
  logic [7:0]  checksum_residual;
  logic [15:0] invalid_total;
  logic [15:0] timeout_total;

  modport source (output valid, output event_kind, output report_id, output byte_index,
                  output payload_byte, output payload_length, output checksum_residual,
                  output invalid_total, output timeout_total, input ready);
  modport sink   (input valid, input event_kind, input report_id, input byte_index,
                  input payload_byte, input payload_length, input checksum_residual,
                  input invalid_total, input timeout_total, output ready);
endinterface

// ----- rtl/core/rfr_fsm.sv -----
// Frame parser: phase state machine, checksum, timeout and counters.
// Updates on each accepted item and flags the event it causes.
// Depends on rfr_pkg.
module rfr_fsm import rfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             func,
  input  logic [ByteW-1:0] rx_byte,
  input  cfg_t             cfg,
  output logic             ev_valid,
  output result_t          ev
);

  phase_t              phase_r, phase_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [ByteW-1:0]    id_r, id_nxt;
  logic [ByteW-1:0]    len_r, len_nxt;
  logic [ByteW-1:0]    taken_r, taken_nxt, taken_inc;
  logic [ByteW-1:0]    sum_r, sum_nxt, sum_add;
  logic [CountW-1:0]   inv_r, inv_nxt;
  logic [CountW-1:0]   tmo_r, tmo_nxt;

  assign sum_add     = sum_r + rx_byte;
  assign taken_inc   = taken_r + 8'd1;
  assign elapsed_inc = (elapsed_r == ElapsedMax) ? elapsed_r : elapsed_r + 17'd1;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    taken_nxt   = taken_r;
    sum_nxt     = sum_r;
    inv_nxt     = inv_r;
    tmo_nxt     = tmo_r;
    ev_valid    = 1'b0;
    ev.event_kind        = EV_PAYLOAD;
    ev.byte_index        = '0;
    ev.payload_byte      = '0;
    ev.checksum_residual = '0;

    if (func) begin
      if (phase_r != PH_START0) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > {1'b0, cfg.timeout_limit_ms}) begin
          tmo_nxt       = tmo_r + 16'd1;
          phase_nxt     = PH_START0;
          ev_valid      = 1'b1;
          ev.event_kind = EV_TIMEOUT;
        end
      end
    end else begin
      unique case (phase_r)
        PH_START1: begin
          if (rx_byte == cfg.second_start_byte) begin
            sum_nxt   = sum_add;
            phase_nxt = PH_ID;
          end else begin
            inv_nxt = inv_r + 16'd1;
          end
        end
        PH_ID: begin
          id_nxt    = rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = rx_byte;
          sum_nxt   = sum_add;
          taken_nxt = '0;
          phase_nxt = (rx_byte != '0) ? PH_PAYLOAD : PH_CHECK;
        end
        PH_PAYLOAD: begin
          sum_nxt         = sum_add;
          taken_nxt       = taken_inc;
          ev_valid        = 1'b1;
          ev.byte_index   = taken_r;
          ev.payload_byte = rx_byte;
          if (taken_inc == len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          sum_nxt              = sum_add;
          phase_nxt            = PH_START0;
          ev_valid             = 1'b1;
          ev.event_kind        = (sum_add == '0) ? EV_GOOD : EV_BAD;
          ev.checksum_residual = sum_add;
        end
        default: begin
          phase_nxt = PH_START0;
          if (rx_byte == cfg.first_start_byte) begin
            sum_nxt     = rx_byte;
            elapsed_nxt = '0;
            id_nxt      = '0;
            len_nxt     = '0;
            taken_nxt   = '0;
            phase_nxt   = PH_START1;
          end else begin
            inv_nxt = inv_r + 16'd1;
          end
        end
      endcase
    end

    ev.report_id      = id_r;
    ev.payload_length = len_r;
    ev.invalid_total  = inv_nxt;
    ev.timeout_total  = tmo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START0;
      elapsed_r <= '0;
      id_r      <= '0;
      len_r     <= '0;
      taken_r   <= '0;
      sum_r     <= '0;
      inv_r     <= '0;
      tmo_r     <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      taken_r   <= taken_nxt;
      sum_r     <= sum_nxt;
      inv_r     <= inv_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

endmodule

// ----- rtl/core/report_frame_receiver_top.sv -----
// Report frame receiver top level: configuration registers, frame parser and
// the result output register. Depends on rfr_pkg, rfr_if and rfr_fsm.
//
// Takes one item (received byte or millisecond tick) per clock. The parser
// state updates at the transfer, and any event it causes appears in the
// output register on the next cycle. The input stays ready every cycle except
// while a result sits in the output register and the sink does not take it,
// so the input takes one item per cycle while the output is not stalled.
module report_frame_receiver_top import rfr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  rfr_in_if.sink              in_ch,
  rfr_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  logic    out_valid_r;
  result_t out_r;
  logic    in_xfer;
  logic    ev_valid;
  result_t ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_start_byte  <= FirstStartRst;
      cfg_r.second_start_byte <= SecondStartRst;
      cfg_r.timeout_limit_ms  <= TimeoutRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_START:  cfg_r.first_start_byte  <= cfg_wdata[ByteW-1:0];
        CFG_SECOND_START: cfg_r.second_start_byte <= cfg_wdata[ByteW-1:0];
        CFG_TIMEOUT:      cfg_r.timeout_limit_ms  <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  rfr_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_xfer),
    .func     (in_ch.func),
    .rx_byte  (in_ch.rx_byte),
    .cfg      (cfg_r),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && ev_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && ev_valid) begin
      out_r <= ev;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.event_kind        = out_r.event_kind;
  assign out_ch.report_id         = out_r.report_id;
  assign out_ch.byte_index        = out_r.byte_index;
  assign out_ch.payload_byte      = out_r.payload_byte;
  assign out_ch.payload_length    = out_r.payload_length;
  assign out_ch.checksum_residual = out_r.checksum_residual;
  assign out_ch.invalid_total     = out_r.invalid_total;
  assign out_ch.timeout_total     = out_r.timeout_total;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input ready while result is stalled");

  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && ev_valid |=> out_ch.valid && out_ch.event_kind == $past(ev.event_kind))
    else $error("event not loaded into output register");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_kind == EV_PAYLOAD |-> out_ch.byte_index < out_ch.payload_length)
    else $error("payload index beyond declared length");

  a_good_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_kind == EV_GOOD |-> out_ch.checksum_residual == 8'd0)
    else $error("good frame with nonzero checksum residual");

endmodule

// ----- test/rfr_event_checker.sv -----
// Event checker for the report frame receiver: follows every transfer on the item and
// event channels and every register write, predicts the events and compares them.
// Depends on rfr_pkg and the channel interfaces in rfr_if.
module rfr_event_checker import rfr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  rfr_in_if                   in_ch,
  rfr_out_if                  out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatch_count,
  output int                  events_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                cfg_q;
  phase_t              ph;
  logic [ElapsedW-1:0] elapsed;
  logic [ByteW-1:0]    fid;
  logic [ByteW-1:0]    flen;
  logic [ByteW-1:0]    taken;
  logic [ByteW-1:0]    sum;
  logic [CountW-1:0]   n_invalid;
  logic [CountW-1:0]   n_timeout;
  result_t             awaited_events[$];

  function automatic bit predict_event(input logic is_tick, input logic [ByteW-1:0] b,
                                       output result_t ev);
    bit made;
    made = 1'b0;
    ev   = '0;
    if (is_tick) begin
      if (ph != PH_START0) begin
        if (elapsed != ElapsedMax) elapsed++;
        if (elapsed > {1'b0, cfg_q.timeout_limit_ms}) begin
          n_timeout++;
          ph            = PH_START0;
          ev.event_kind = EV_TIMEOUT;
          made          = 1'b1;
        end
      end
    end else begin
      case (ph)
        PH_START0: begin
          if (b == cfg_q.first_start_byte) begin
            sum     = b;
            elapsed = '0;
            fid     = '0;
            flen    = '0;
            taken   = '0;
            ph      = PH_START1;
          end else begin
            n_invalid++;
          end
        end
        PH_START1: begin
          if (b == cfg_q.second_start_byte) begin
            sum = sum + b;
            ph  = PH_ID;
          end else begin
            n_invalid++;
          end
        end
        PH_ID: begin
          fid = b;
          sum = sum + b;
          ph  = PH_LEN;
        end
        PH_LEN: begin
          flen  = b;
          sum   = sum + b;
          taken = '0;
          ph    = (b != '0) ? PH_PAYLOAD : PH_CHECK;
        end
        PH_PAYLOAD: begin
          sum             = sum + b;
          ev.event_kind   = EV_PAYLOAD;
          ev.byte_index   = taken;
          ev.payload_byte = b;
          taken++;
          if (taken == flen) ph = PH_CHECK;
          made = 1'b1;
        end
        default: begin
          sum                  = sum + b;
          ph                   = PH_START0;
          ev.event_kind        = (sum == '0) ? EV_GOOD : EV_BAD;
          ev.checksum_residual = sum;
          made                 = 1'b1;
        end
      endcase
    end
    ev.report_id      = fid;
    ev.payload_length = flen;
    ev.invalid_total  = n_invalid;
    ev.timeout_total  = n_timeout;
    return made;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t ev;
    result_t want;
    if (!rst_n) begin
      cfg_q.first_start_byte  = FirstStartRst;
      cfg_q.second_start_byte = SecondStartRst;
      cfg_q.timeout_limit_ms  = TimeoutRst;
      ph        = PH_START0;
      elapsed   = '0;
      fid       = '0;
      flen      = '0;
      taken     = '0;
      sum       = '0;
      n_invalid = '0;
      n_timeout = '0;
      awaited_events.delete();
      mismatch_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_events.size() == 0) begin
          $error("event_kind: expected no transfer, actual %0d", out_ch.event_kind);
          mismatch_count++;
        end else begin
          want = awaited_events.pop_front();
          check_field("event_kind", want.event_kind, out_ch.event_kind);
          check_field("report_id", want.report_id, out_ch.report_id);
          check_field("byte_index", want.byte_index, out_ch.byte_index);
          check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
          check_field("payload_length", want.payload_length, out_ch.payload_length);
          check_field("checksum_residual", want.checksum_residual,
                      out_ch.checksum_residual);
          check_field("invalid_total", want.invalid_total, out_ch.invalid_total);
          check_field("timeout_total", want.timeout_total, out_ch.timeout_total);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_event(in_ch.func, in_ch.rx_byte, ev)) awaited_events.push_back(ev);
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FIRST_START:  cfg_q.first_start_byte  = cfg_wdata[ByteW-1:0];
          CFG_SECOND_START: cfg_q.second_start_byte = cfg_wdata[ByteW-1:0];
          CFG_TIMEOUT:      cfg_q.timeout_limit_ms  = cfg_wdata[CountW-1:0];
          default: ;
        endcase
      end
    end
    events_waiting = awaited_events.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the report frame receiver: clock, reset, frame and tick stimulus
// with bursty sending and receiver stalls, register settings and the verdict.
// Depends on rfr_pkg, rfr_if, report_frame_receiver_top and rfr_event_checker.
module tb_top import rfr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  mismatch_count;
  int                  events_waiting;

  rfr_in_if  in_ch();
  rfr_out_if out_ch();

  report_frame_receiver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rfr_event_checker events_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .events_waiting (events_waiting)
  );

  logic [ByteW-1:0]  cur_first   = FirstStartRst;
  logic [ByteW-1:0]  cur_second  = SecondStartRst;
  logic [CountW-1:0] cur_timeout = TimeoutRst;
  int                burst_left  = 0;
  int                items_sent  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("report_frame_receiver_top verification failed");
    $finish;
  end

  // receiver: free running, random, periodic and mostly-stalled stretches
  initial begin : stall_pattern
    int mode;
    int span;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 200);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= (i % 3 != 0);
          default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic is_tick, input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= is_tick;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold the sender until every predicted event has been taken
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (events_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [ByteW-1:0] f, input logic [ByteW-1:0] s,
                           input logic [CountW-1:0] t);
    drain();
    write_reg(CFG_FIRST_START, {8'h00, f});
    write_reg(CFG_SECOND_START, {8'h00, s});
    write_reg(CFG_TIMEOUT, t);
    cur_first   = f;
    cur_second  = s;
    cur_timeout = t;
  endtask

  // garble inserts a rejected second start byte; ticks are mixed in at tick_pct
  task automatic send_frame(input logic [ByteW-1:0] id, input int len, input bit bad,
                            input bit garble, input int tick_pct);
    logic [ByteW-1:0] seq[$];
    logic [ByteW-1:0] total;
    logic [ByteW-1:0] b;
    seq.push_back(cur_first);
    if (garble) seq.push_back(cur_second ^ 8'($urandom_range(1, 255)));
    seq.push_back(cur_second);
    seq.push_back(id);
    seq.push_back(8'(len));
    total = cur_first + cur_second + id + 8'(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      seq.push_back(b);
      total = total + b;
    end
    b = -total;
    if (bad) b = b + 8'($urandom_range(1, 255));
    seq.push_back(b);
    foreach (seq[i]) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(1'b1, 8'($urandom));
      send_item(1'b0, seq[i]);
    end
  endtask

  initial begin : stimulus
    int start;
    int r;
    int len;
    int tick_pct;
    int run;
    in_ch.valid   = 1'b0;
    in_ch.func    = 1'b0;
    in_ch.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle tick, rejected first bytes, rejected second byte, zero length,
    // ticks inside a frame, bad checksum
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_frame(8'h00, 0, 1'b0, 1'b1, 0);
    send_frame(8'hFF, 2, 1'b0, 1'b0, 50);
    send_frame(8'h5A, 1, 1'b1, 1'b0, 0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: ;
        1: begin
          configure(8'h00, 8'hFF, 16'd0);
          // zero limit: first tick in a frame abandons it
          send_item(1'b0, 8'h00);
          send_item(1'b1, 8'h00);
        end
        2: configure(8'hFF, 8'h00, 16'd1);
        3: configure(8'hBE, 8'hEF, 16'hFFFF);
        4: configure(8'($urandom), 8'($urandom), 16'($urandom_range(2, 12)));
        5: begin
          r = $urandom_range(0, 255);
          configure(8'(r), 8'(r), 16'd5);
        end
        6: configure(8'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)));
        default: configure(FirstStartRst, SecondStartRst, TimeoutRst);
      endcase
      tick_pct = (cur_timeout <= 12) ? 4 : 25;
      start = items_sent;
      while (items_sent - start < 240) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          r = $urandom_range(0, 99);
          len = (r < 1) ? 255 : (r < 4) ? $urandom_range(16, 64) : $urandom_range(0, 10);
          send_frame(8'($urandom), len, ($urandom_range(0, 5) == 0),
                     ($urandom_range(0, 11) == 0), tick_pct);
        end else if (r < 75) begin
          send_item(1'b0, cur_first);
          if ($urandom_range(0, 1) == 1) send_item(1'b0, cur_second);
        end else if (r < 85) begin
          // tick run around the limit when it is below 200, else a short run
          run = (cur_timeout < 200) ? int'(cur_timeout) + $urandom_range(0, 2)
                                    : $urandom_range(1, 20);
          send_item(1'b0, cur_first);
          repeat (run) send_item(1'b1, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 8))
            send_item(($urandom_range(0, 3) == 0), 8'($urandom));
        end
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && events_waiting == 0) begin
      $display("report_frame_receiver_top verification clean");
    end else begin
      $display("report_frame_receiver_top verification failed");
    end
    $finish;
  end

endmodule

// ----- report_frame_receiver_top.f -----
rtl/core/rfr_pkg.sv
rtl/core/rfr_if.sv
rtl/core/rfr_fsm.sv
rtl/core/report_frame_receiver_top.sv
test/rfr_event_checker.sv
test/tb_top.sv
